FILE: rtl/core/u8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Item layouts of both channels, decoder state and the per-byte result set.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int CNT_W  = 2;

  // Code point given for any malformed input
  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  // Continuation counts of the four lead byte forms
  localparam logic [CNT_W-1:0] NEED_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] NEED_TWO   = 2'd1;
  localparam logic [CNT_W-1:0] NEED_THREE = 2'd2;
  localparam logic [CNT_W-1:0] NEED_FOUR  = 2'd3;

  // Payload of one input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  // Payload of one output transaction
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            run_last;
  } out_item_t;

  // Open sequence state
  typedef struct packed {
    logic [CNT_W-1:0] needed;
    logic [CNT_W-1:0] seen;
    logic [CP_W-1:0]  partial;
  } dec_state_t;

  // Results caused by one byte: count, then two leading values; any further
  // result is a replacement
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CP_W-1:0]  cp0;
    logic [CP_W-1:0]  cp1;
  } dec_result_t;

endpackage

FILE: rtl/core/u8sd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_stream_if: valid/ready channel
// Carries one payload per transaction; the type of the payload is a parameter.
// ----------------------------------------------------------------------------
interface u8sd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/core/u8sd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_decode: single-byte decode step
// From the open sequence state and one byte, work out the next state and
// the up to three code points this byte produces.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  u8sd_pkg::dec_state_t           state,
  input  logic [u8sd_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           end_of_stream,
  output u8sd_pkg::dec_state_t           state_next,
  output u8sd_pkg::dec_result_t          result
);

  typedef struct packed {
    logic                          emit;
    logic [u8sd_pkg::CP_W-1:0]     value;
    logic                          opens;
    logic [u8sd_pkg::CNT_W-1:0]    needed;
    logic [u8sd_pkg::CP_W-1:0]     partial;
  } start_t;

  localparam u8sd_pkg::dec_state_t CLOSED = '0;

  // Decode a byte as if no sequence were open
  function automatic start_t start_byte(input logic [u8sd_pkg::BYTE_W-1:0] b);
    start_t s;
    s = '0;
    if (b[7] == 1'b0) begin
      s.emit  = 1'b1;
      s.value = {{(u8sd_pkg::CP_W-u8sd_pkg::BYTE_W){1'b0}}, b};
    end else if (b[7:5] == 3'b110) begin
      s.opens   = 1'b1;
      s.needed  = u8sd_pkg::NEED_TWO;
      s.partial = {{(u8sd_pkg::CP_W-5){1'b0}}, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      s.opens   = 1'b1;
      s.needed  = u8sd_pkg::NEED_THREE;
      s.partial = {{(u8sd_pkg::CP_W-4){1'b0}}, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      s.opens   = 1'b1;
      s.needed  = u8sd_pkg::NEED_FOUR;
      s.partial = {{(u8sd_pkg::CP_W-3){1'b0}}, b[2:0]};
    end else begin
      s.emit  = 1'b1;
      s.value = u8sd_pkg::REPLACEMENT;
    end
    return s;
  endfunction

  start_t                       st;
  logic                         is_cont;
  logic [u8sd_pkg::CP_W-1:0]    shifted;
  logic [u8sd_pkg::CNT_W-1:0]   seen_inc;
  u8sd_pkg::dec_state_t         mid;
  logic [u8sd_pkg::CNT_W-1:0]   base;
  logic [u8sd_pkg::CNT_W:0]     total;
  logic [u8sd_pkg::CP_W-1:0]    v0;
  logic [u8sd_pkg::CP_W-1:0]    v1;

  assign st       = start_byte(data_byte);
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign shifted  = {state.partial[u8sd_pkg::CP_W-7:0], data_byte[5:0]};
  assign seen_inc = state.seen + 2'd1;

  // Byte step, then the truncated-tail flush
  always_comb begin
    mid   = state;
    base  = 2'd0;
    v0    = u8sd_pkg::REPLACEMENT;
    v1    = u8sd_pkg::REPLACEMENT;
    total = '0;

    if (state.needed == u8sd_pkg::NEED_NONE) begin
      if (st.emit) begin
        base = 2'd1;
        v0   = st.value;
      end else begin
        mid = '{needed: st.needed, seen: '0, partial: st.partial};
      end
    end else if (is_cont) begin
      if (seen_inc >= state.needed) begin
        base = 2'd1;
        v0   = shifted;
        mid  = CLOSED;
      end else begin
        mid = '{needed: state.needed, seen: seen_inc, partial: shifted};
      end
    end else begin
      // Broken sequence: replace, then decode the byte again as a lead
      base = 2'd1;
      mid  = CLOSED;
      if (st.emit) begin
        base = 2'd2;
        v1   = st.value;
      end else begin
        mid = '{needed: st.needed, seen: '0, partial: st.partial};
      end
    end

    total = {1'b0, base};
    if (end_of_stream && (mid.needed != u8sd_pkg::NEED_NONE)) begin
      total = {1'b0, base} + 3'd1 + {1'b0, mid.seen};
      mid   = CLOSED;
    end

    state_next   = mid;
    result.count = (total > 3'd3) ? 2'd3 : total[u8sd_pkg::CNT_W-1:0];
    result.cp0   = v0;
    result.cp1   = v1;
  end

endmodule

FILE: rtl/core/u8sd_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_emit: result register and output sequencer
// Holds the results of one byte and hands them out one transaction a cycle while the output is ready.
// ----------------------------------------------------------------------------
module u8sd_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_valid,
  input  u8sd_pkg::dec_result_t  wr_result,
  output logic                   free,
  u8sd_stream_if.source          code_stream
);

  logic [u8sd_pkg::CNT_W-1:0] count;
  logic [u8sd_pkg::CP_W-1:0]  cp0;
  logic [u8sd_pkg::CP_W-1:0]  cp1;
  logic                       fire;

  assign fire = code_stream.valid && code_stream.ready;
  assign free = (count == 2'd0) || (fire && (count == 2'd1));

  // Track how many results are left
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_valid) begin
      count <= wr_result.count;
    end else if (fire) begin
      count <= count - 2'd1;
    end
  end

  // Load a new result set or advance to the next value
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      cp0 <= wr_result.cp0;
      cp1 <= wr_result.cp1;
    end else if (fire) begin
      cp0 <= cp1;
      cp1 <= u8sd_pkg::REPLACEMENT;
    end
  end

  assign code_stream.valid              = (count != 2'd0);
  assign code_stream.payload.code_point = cp0;
  assign code_stream.payload.run_last   = (count == 2'd1);

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// Timing: a byte's transaction loads the input register; once the result register is free,
// the decode step writes the byte's results into it and the first of them is offered.
// Throughput: one byte per cycle while the result register is free; a byte that yields
// several results holds it until each is taken, so such bytes slow intake to the output rate.
// Reset: synchronous rst closes any open sequence and empties both the input and the
// result register; no result is offered until new bytes arrive.
// ----------------------------------------------------------------------------
// utf8_stream_decoder: byte-serial UTF-8 decoder
// Input register, combinational decode step with sequence state, and a result
// register that replays replacement code points when one byte yields several.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  u8sd_stream_if.sink   byte_stream,
  u8sd_stream_if.source code_stream
);

  logic                   s1_valid;
  u8sd_pkg::in_item_t     s1_item;
  logic                   s1_advance;
  logic                   rb_free;
  u8sd_pkg::dec_state_t   state;
  u8sd_pkg::dec_state_t   state_next;
  u8sd_pkg::dec_result_t  result;

  assign s1_advance        = s1_valid && rb_free;
  assign byte_stream.ready = !s1_valid || s1_advance;

  // Hold the incoming byte until the decode step takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      s1_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      s1_item <= byte_stream.payload;
    end
  end

  // Advance the sequence state once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  u8sd_decode u_decode (
    .state         (state),
    .data_byte     (s1_item.data_byte),
    .end_of_stream (s1_item.end_of_stream),
    .state_next    (state_next),
    .result        (result)
  );

  u8sd_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .wr_valid    (s1_advance),
    .wr_result   (result),
    .free        (rb_free),
    .code_stream (code_stream)
  );

  // Only the final result of a byte can carry a real code point
  a_nonlast_is_repl: assert property (@(posedge clk) disable iff (rst)
    (code_stream.valid && !code_stream.payload.run_last)
      |-> (code_stream.payload.code_point == u8sd_pkg::REPLACEMENT))
    else $error("non-final result is not a replacement");

  // No continuation count without an open sequence
  a_closed_clean: assert property (@(posedge clk) disable iff (rst)
    (state.needed == u8sd_pkg::NEED_NONE) |-> (state.seen == 2'd0))
    else $error("seen count set with no sequence open");

  // An open sequence always waits for at least one more byte
  a_open_pending: assert property (@(posedge clk) disable iff (rst)
    (state.needed != u8sd_pkg::NEED_NONE) |-> (state.seen < state.needed))
    else $error("open sequence already complete");

  // End of stream always leaves no sequence open
  a_eos_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_item.end_of_stream) |=> (state.needed == u8sd_pkg::NEED_NONE))
    else $error("sequence left open after end of stream");

endmodule
